FILE: src/swh_pkg.sv
package swh_pkg;
  localparam int BUCKETS_DEF = 64;
  localparam int WINDOW_DEF  = 256;

  localparam logic [2:0] CMD_CLEAR = 3'd0;
  localparam logic [2:0] CMD_ADD   = 3'd1;
  localparam logic [2:0] CMD_LOWER = 3'd2;
  localparam logic [2:0] CMD_UPPER = 3'd3;
  localparam logic [2:0] CMD_MEAN  = 3'd4;

  localparam logic CFG_LOW_BOUND = 1'b0;
  localparam logic CFG_BIN_SCALE = 1'b1;
endpackage

FILE: src/sliding_window_histogram.sv
// Channel | Direction | Handshake             | Payload
// in      | input     | in_valid / in_stall   | in_cmd, in_sample, in_fraction
// out     | output    | out_valid / out_stall | out_bin_index .. out_mean_bins
// cfg     | input     | cfg_we                | cfg_index, cfg_data
// An add reads the ring, then does a read-modify-write of the old bin (only once the window
// is full) and of the new bin in the count memory before it reports.
// Percentile queries walk one bin a cycle. Mean adds a 32-step serial divide after the walk,
// skipped when no sample is in range. Undefined codes go straight to the result.
// Clear sweeps the count memory and then reports; reset runs the same sweep before the
// first transfer. The next transfer is taken the cycle after the result is loaded; a
// result held by out_stall keeps the following item in its last state.
module sliding_window_histogram #(
  parameter int BUCKETS = swh_pkg::BUCKETS_DEF,
  parameter int WINDOW  = swh_pkg::WINDOW_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_cmd,
  input  logic signed [31:0] in_sample,
  input  logic [16:0]        in_fraction,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [7:0]  out_bin_index,
  output logic [8:0]         out_in_range_count,
  output logic [8:0]         out_window_count,
  output logic [31:0]        out_forgotten_count,
  output logic [13:0]        out_mean_bins,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data
);
  localparam int NB  = BUCKETS + 2;
  localparam int BAW = $clog2(NB);
  localparam int RAW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int IW  = $clog2(BUCKETS + 2) + 1;
  localparam int AW  = 32;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLR   = 4'd1;
  localparam logic [3:0] S_Q     = 4'd2;
  localparam logic [3:0] S_RING  = 4'd3;
  localparam logic [3:0] S_OLDW  = 4'd4;
  localparam logic [3:0] S_NEWR  = 4'd5;
  localparam logic [3:0] S_NEWW  = 4'd6;
  localparam logic [3:0] S_WALK  = 4'd7;
  localparam logic [3:0] S_DIV   = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;
  localparam logic [3:0] S_OLDR  = 4'd10;
  localparam logic [3:0] S_DST   = 4'd11;

  logic [3:0] st_r;
  logic signed [31:0] low_r;
  logic [31:0] scale_r;
  logic [2:0] cmd_r;
  logic [16:0] frac_r;
  logic signed [32:0] diff_r;
  logic [63:0] prod_r;
  logic [RAW-1:0] pos_r;
  logic [8:0] inside_r, all_r;
  logic [31:0] evict_r;
  logic signed [IW-1:0] new_r, old_r;
  logic [BAW-1:0] addr_r;
  logic [BAW:0] walk_r;
  logic [9:0] sum_r;
  logic [25:0] tgt_r;
  logic found_r;
  logic signed [IW-1:0] ans_r;
  logic [AW-1:0] acc_r;

  // Count memory.
  logic cm_we;
  logic [BAW-1:0] cm_waddr, cm_raddr;
  logic [8:0] cm_wdata, cm_rdata;
  swh_ram #(.DEPTH(NB), .WIDTH(9)) u_counts (
    .clk(clk), .we(cm_we), .waddr(cm_waddr), .wdata(cm_wdata),
    .raddr(cm_raddr), .rdata(cm_rdata));

  // Ring memory of bin slots. An entry is live once the window is full.
  logic rg_we;
  logic [BAW-1:0] rg_rdata;
  swh_ram #(.DEPTH(WINDOW), .WIDTH(BAW)) u_ring (
    .clk(clk), .we(rg_we), .waddr(pos_r), .wdata(BAW'(new_r + 1)),
    .raddr(pos_r), .rdata(rg_rdata));

  logic div_start, div_done;
  logic [AW-1:0] div_q;
  swh_div #(.NW(AW), .DW(9)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(acc_r),
    .den(inside_r), .done(div_done), .quo(div_q));

  logic out_load;
  assign in_stall = (st_r != S_IDLE);
  assign out_load = (st_r == S_OUT) && (!out_valid || !out_stall);

  // Bin handled by the walk in this cycle: upward for lower and mean, downward for upper.
  logic [BAW-1:0] walk_bin;
  logic [BAW+8:0] wprod;
  assign walk_bin = (cmd_r == swh_pkg::CMD_UPPER) ? BAW'(BUCKETS - int'(walk_r))
                                                  : BAW'(walk_r - 1'b1);
  assign wprod = (BAW+9)'(cm_rdata) * (BAW+9)'(walk_bin);

  // Memory port control per state.
  always_comb begin
    cm_we = 1'b0;
    cm_waddr = addr_r;
    cm_wdata = '0;
    cm_raddr = addr_r;
    rg_we = 1'b0;
    div_start = 1'b0;
    unique case (st_r)
      S_CLR:  cm_we = 1'b1;
      S_OLDR: cm_raddr = BAW'(old_r + 1);
      S_OLDW: begin
        cm_we = 1'b1;
        cm_waddr = BAW'(old_r + 1);
        cm_wdata = cm_rdata - 9'd1;
      end
      S_NEWR: cm_raddr = BAW'(new_r + 1);
      S_NEWW: begin
        cm_we = 1'b1;
        cm_waddr = BAW'(new_r + 1);
        cm_wdata = cm_rdata + 9'd1;
        rg_we = 1'b1;
      end
      S_WALK: cm_raddr = (cmd_r == swh_pkg::CMD_UPPER) ? BAW'(BUCKETS - int'(walk_r))
                                                       : BAW'(walk_r + 1'b1);
      S_DST:  div_start = 1'b1;
      default: ;
    endcase
  end

  logic [31:0] diff_mag;
  assign diff_mag = diff_r[32] ? 32'(-diff_r) : diff_r[31:0];

  logic signed [IW-1:0] qbin;
  logic [32:0] rounded;
  always_comb begin
    rounded = 33'(prod_r[63:31]) + 33'd1;
    if (diff_r < 0) begin
      qbin = (prod_r > 64'h8000_0000) ? -IW'(1) : '0;
    end else if (rounded[32:1] > 32'(BUCKETS)) begin
      qbin = IW'(BUCKETS);
    end else begin
      qbin = IW'(rounded[32:1]);
    end
  end

  logic [9:0] sum_nxt;
  assign sum_nxt = sum_r + {1'b0, cm_rdata};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR;
      addr_r <= '0;
      low_r <= '0;
      scale_r <= 32'd65536;
      out_valid <= 1'b0;
      pos_r <= '0;
      inside_r <= '0;
      all_r <= '0;
      evict_r <= '0;
      // Any code but clear ends the reset sweep without a result.
      cmd_r <= swh_pkg::CMD_ADD;
    end else begin
      if (cfg_we) begin
        if (cfg_index == swh_pkg::CFG_LOW_BOUND) low_r <= cfg_data;
        else scale_r <= cfg_data;
      end
      if (out_load) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (st_r)
        S_IDLE: if (in_valid) begin
          cmd_r <= in_cmd;
          frac_r <= in_fraction;
          diff_r <= 33'(in_sample) - 33'(low_r);
          sum_r <= '0;
          found_r <= 1'b0;
          acc_r <= '0;
          walk_r <= '0;
          unique case (in_cmd)
            swh_pkg::CMD_CLEAR: begin
              pos_r <= '0;
              inside_r <= '0;
              all_r <= '0;
              evict_r <= '0;
              addr_r <= '0;
              st_r <= S_CLR;
            end
            swh_pkg::CMD_ADD: st_r <= S_Q;
            swh_pkg::CMD_LOWER, swh_pkg::CMD_UPPER, swh_pkg::CMD_MEAN: begin
              st_r <= S_WALK;
              ans_r <= (in_cmd == swh_pkg::CMD_UPPER) ? -IW'(1) : IW'(BUCKETS);
            end
            default: st_r <= S_OUT;
          endcase
        end
        S_CLR: begin
          addr_r <= addr_r + 1'b1;
          if (addr_r == BAW'(NB - 1)) st_r <= (cmd_r == swh_pkg::CMD_CLEAR) ?
              S_OUT : S_IDLE;
        end
        S_Q: begin
          prod_r <= 64'(diff_mag) * 64'(scale_r);
          tgt_r <= '0;
          st_r <= S_RING;
        end
        S_RING: begin
          new_r <= qbin;
          st_r <= (all_r == 9'(WINDOW)) ? S_OLDR : S_NEWR;
          old_r <= IW'($signed({1'b0, rg_rdata})) - IW'(1);
        end
        S_OLDR: st_r <= S_OLDW;
        S_OLDW: begin
          all_r <= all_r - 1'b1;
          if (old_r >= 0 && old_r < IW'(BUCKETS)) inside_r <= inside_r - 1'b1;
          evict_r <= evict_r + 1'b1;
          st_r <= S_NEWR;
        end
        S_NEWR: st_r <= S_NEWW;
        S_NEWW: begin
          pos_r <= (pos_r == RAW'(WINDOW - 1)) ? '0 : pos_r + 1'b1;
          all_r <= all_r + 1'b1;
          if (new_r >= 0 && new_r < IW'(BUCKETS)) inside_r <= inside_r + 1'b1;
          ans_r <= new_r;
          st_r <= S_OUT;
        end
        S_WALK: begin
          // Address order: lower and mean go up from slot 1, upper goes down.
          if (walk_r == '0) begin
            tgt_r <= 26'((27'(inside_r) * 27'(frac_r)) >> 16);
          end else begin
            sum_r <= sum_nxt;
            acc_r <= acc_r + AW'({wprod, 8'd0});
            if (!found_r && cmd_r != swh_pkg::CMD_MEAN && 26'(sum_nxt) >= tgt_r)
            begin
              found_r <= 1'b1;
              ans_r <= IW'(walk_bin);
            end
          end
          walk_r <= walk_r + 1'b1;
          if (walk_r == (BAW+1)'(BUCKETS)) begin
            st_r <= (cmd_r == swh_pkg::CMD_MEAN && inside_r != 9'd0) ? S_DST : S_OUT;
          end
        end
        S_DST: st_r <= S_DIV;
        S_DIV: if (div_done) begin
          acc_r <= div_q;
          st_r <= S_OUT;
        end
        S_OUT: if (out_load) begin
          out_bin_index <= (cmd_r == swh_pkg::CMD_ADD || cmd_r == swh_pkg::CMD_LOWER
              || cmd_r == swh_pkg::CMD_UPPER) ? 8'(ans_r) : 8'sd0;
          out_in_range_count <= inside_r;
          out_window_count <= all_r;
          out_forgotten_count <= evict_r;
          out_mean_bins <= (cmd_r == swh_pkg::CMD_MEAN) ? acc_r[13:0] : 14'd0;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  // A waiting result keeps its value.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_bin_index)
      && $stable(out_in_range_count) && $stable(out_window_count)
      && $stable(out_forgotten_count) && $stable(out_mean_bins));

  // The state stays among the defined codes.
  assert property (@(posedge clk) disable iff (!rst_n) st_r <= S_DST);

  // In-range samples never outnumber the window, which never exceeds its size.
  assert property (@(posedge clk) disable iff (!rst_n) inside_r <= all_r);
  assert property (@(posedge clk) disable iff (!rst_n) all_r <= 9'(WINDOW));
endmodule

FILE: src/swh_ram.sv
// Simple dual-port RAM: one write port and one registered read port.
module swh_ram #(
  parameter int DEPTH = 66,
  parameter int WIDTH = 9
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: src/swh_div.sv
// Restoring divider, one quotient bit per cycle.
module swh_div #(
  parameter int NW = 32,
  parameter int DW = 9
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);
  localparam int CW = $clog2(NW + 1);
  logic [NW-1:0] q_r;
  logic [DW:0]   rem_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic [DW:0]   trial;

  assign trial = {rem_r[DW-1:0], q_r[NW-1]};
  assign quo = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        q_r    <= num;
        rem_r  <= '0;
        cnt_r  <= CW'(NW);
      end else if (busy_r) begin
        if (trial >= {1'b0, den}) begin
          rem_r <= trial - {1'b0, den};
          q_r   <= {q_r[NW-2:0], 1'b1};
        end else begin
          rem_r <= trial;
          q_r   <= {q_r[NW-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end
endmodule
